// ----- src/deque_with_remove_by_value_unit_macros.svh -----
// Assertion macros for the deque unit.
`ifndef DEQUE_WITH_REMOVE_BY_VALUE_UNIT_MACROS_SVH
`define DEQUE_WITH_REMOVE_BY_VALUE_UNIT_MACROS_SVH

`ifndef SYNTH
`define DWRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");
`define DWRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DWRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DWRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/dwrv_pkg.sv -----
package dwrv_pkg;

    localparam int DEPTH   = 16;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FIND       = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value_out;
        logic [COUNT_W-1:0]       count;
    } rsp_item_t;

    // per-transaction command broadcast to every cell
    typedef struct packed {
        logic                     push_front;
        logic                     push_back;
        logic                     pop_front;
        logic                     remove;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

    // where a cell sits relative to the current occupancy
    typedef struct packed {
        logic in_use;
        logic is_last;
        logic is_free;
    } cell_pos_t;

endpackage

// ----- src/dwrv_cell.sv -----
module dwrv_cell (
    input  logic                             clk,
    input  dwrv_pkg::cell_ctrl_t             ctrl,
    input  dwrv_pkg::cell_pos_t              pos,
    input  logic signed [dwrv_pkg::DATA_W-1:0] left_data,
    input  logic signed [dwrv_pkg::DATA_W-1:0] right_data,
    input  logic                             hit_in,
    output logic signed [dwrv_pkg::DATA_W-1:0] data,
    output logic signed [dwrv_pkg::DATA_W-1:0] tail_data,
    output logic                             hit_out
);

    logic signed [dwrv_pkg::DATA_W-1:0] data_reg;
    logic signed [dwrv_pkg::DATA_W-1:0] data_next;
    logic                               match;

    assign match     = pos.in_use && (data_reg == ctrl.value);
    assign hit_out   = hit_in || match;
    assign data      = data_reg;
    assign tail_data = pos.is_last ? data_reg : '0;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_front)
        begin
            data_next = left_data;
        end
        else if (ctrl.push_back && pos.is_free)
        begin
            data_next = ctrl.value;
        end
        else if (ctrl.pop_front || (ctrl.remove && hit_out))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- src/deque_with_remove_by_value_unit.sv -----
// Deque with remove-by-value, built as a row of DEPTH storage cells.
// Response: registered in the output register when the request is accepted.
// Throughput: one transaction per cycle unless rsp_stall holds a valid response;
// the cycle is bounded by the match chain through all cells for remove and find.
// Reset: rst_n asynchronous, active low; clears occupancy and the response valid.
// Cell contents are not reset and read only below occupancy.
`include "deque_with_remove_by_value_unit_macros.svh"

module deque_with_remove_by_value_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  dwrv_pkg::req_item_t   req_item,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output dwrv_pkg::rsp_item_t   rsp_item
);

    localparam int DEPTH  = dwrv_pkg::DEPTH;
    localparam int OCC_W  = dwrv_pkg::OCC_W;
    localparam int DATA_W = dwrv_pkg::DATA_W;

    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    dwrv_pkg::rsp_item_t    rsp_reg;
    dwrv_pkg::rsp_item_t    rsp_next;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   found;
    logic                   push_ok;
    logic                   rsp_is_empty;
    logic                   is_pf;
    logic                   is_pb;
    logic                   is_popf;
    logic                   is_popb;
    logic                   is_rem;
    logic                   is_find;
    logic signed [DATA_W-1:0] tail_val;

    dwrv_pkg::cell_ctrl_t     ctrl;
    logic signed [DATA_W-1:0] data_w [DEPTH];
    logic signed [DATA_W-1:0] tail_w [DEPTH];
    logic                     hit_w  [DEPTH+1];

    assign accept    = req_valid && !req_stall;
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    assign full  = (occ_reg == OCC_W'(DEPTH));
    assign empty = (occ_reg == '0);

    assign is_pf   = (req_item.action == dwrv_pkg::ACT_PUSH_FRONT);
    assign is_pb   = (req_item.action == dwrv_pkg::ACT_PUSH_BACK);
    assign is_popf = (req_item.action == dwrv_pkg::ACT_POP_FRONT);
    assign is_popb = (req_item.action == dwrv_pkg::ACT_POP_BACK);
    assign is_rem  = (req_item.action == dwrv_pkg::ACT_REMOVE);
    assign is_find = (req_item.action == dwrv_pkg::ACT_FIND);

    assign ctrl.push_front = accept && is_pf && !full;
    assign ctrl.push_back  = accept && is_pb && !full;
    assign ctrl.pop_front  = accept && is_popf && !empty;
    assign ctrl.remove     = accept && is_rem;
    assign ctrl.value      = req_item.value;

    assign push_ok      = ctrl.push_front || ctrl.push_back;
    assign rsp_is_empty = rsp_valid_reg && (rsp_reg.status == dwrv_pkg::ST_EMPTY);

    assign hit_w[0] = 1'b0;
    assign found    = hit_w[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dwrv_pkg::cell_pos_t      pos;
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        assign pos.in_use  = (OCC_W'(i) < occ_reg);
        assign pos.is_last = (OCC_W'(i + 1) == occ_reg);
        assign pos.is_free = (OCC_W'(i) == occ_reg);

        if (i == 0)
        begin : g_first
            assign left_d = req_item.value;
        end
        else
        begin : g_mid_l
            assign left_d = data_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = data_w[i];
        end
        else
        begin : g_mid_r
            assign right_d = data_w[i+1];
        end

        dwrv_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .pos        (pos),
            .left_data  (left_d),
            .right_data (right_d),
            .hit_in     (hit_w[i]),
            .data       (data_w[i]),
            .tail_data  (tail_w[i]),
            .hit_out    (hit_w[i+1])
        );
    end

    always_comb
    begin
        tail_val = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            tail_val = tail_val | tail_w[k];
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (push_ok)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctrl.pop_front || (accept && is_popb && !empty) || (ctrl.remove && found))
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_comb
    begin
        rsp_next.status    = dwrv_pkg::ST_DONE;
        rsp_next.value_out = '0;
        if ((is_pf || is_pb) && full)
        begin
            rsp_next.status = dwrv_pkg::ST_FULL;
        end
        else if ((is_popf || is_popb) && empty)
        begin
            rsp_next.status = dwrv_pkg::ST_EMPTY;
        end
        else if ((is_rem || is_find) && !found)
        begin
            rsp_next.status = dwrv_pkg::ST_NOTFOUND;
        end
        else if (is_popf)
        begin
            rsp_next.value_out = data_w[0];
        end
        else if (is_popb)
        begin
            rsp_next.value_out = tail_val;
        end
        rsp_next.count = dwrv_pkg::COUNT_W'(occ_next);
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    `DWRV_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(DEPTH))
    `DWRV_ASSERT_NXT(a_push_grows, clk, rst_n, push_ok, occ_reg == $past(occ_reg) + OCC_W'(1))
    `DWRV_ASSERT_IMP(a_empty_count, clk, rst_n, rsp_is_empty, rsp_reg.count == '0)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam logic [dwrv_pkg::ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [dwrv_pkg::ACT_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam logic signed [dwrv_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [dwrv_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 80;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    dwrv_pkg::req_item_t req_item;
    logic                rsp_valid;
    logic                rsp_stall;
    dwrv_pkg::rsp_item_t rsp_item;

    logic signed [dwrv_pkg::DATA_W-1:0] deque_entries [dwrv_pkg::DEPTH];
    int                                 deque_occupancy;
    dwrv_pkg::rsp_item_t                expected_results [$];

    int mismatches;
    int cycle_count;
    int burst_left;
    bit sender_gaps;
    bit hold_request;

    deque_with_remove_by_value_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always #1 clk = ~clk;

    function automatic dwrv_pkg::rsp_item_t deque_apply(input dwrv_pkg::req_item_t it);
        dwrv_pkg::rsp_item_t r;
        int                  i;
        int                  pos;
        r.status = dwrv_pkg::ST_DONE;
        r.value_out = '0;
        pos = deque_occupancy;
        if (it.action == dwrv_pkg::ACT_REMOVE || it.action == dwrv_pkg::ACT_FIND)
        begin
            for (i = deque_occupancy - 1; i >= 0; i--)
            begin
                if (deque_entries[i] == it.value)
                    pos = i;
            end
        end
        case (it.action)
            dwrv_pkg::ACT_PUSH_FRONT:
            begin
                if (deque_occupancy >= dwrv_pkg::DEPTH)
                    r.status = dwrv_pkg::ST_FULL;
                else
                begin
                    for (i = deque_occupancy; i > 0; i--)
                        deque_entries[i] = deque_entries[i-1];
                    deque_entries[0] = it.value;
                    deque_occupancy++;
                end
            end
            dwrv_pkg::ACT_PUSH_BACK:
            begin
                if (deque_occupancy >= dwrv_pkg::DEPTH)
                    r.status = dwrv_pkg::ST_FULL;
                else
                begin
                    deque_entries[deque_occupancy] = it.value;
                    deque_occupancy++;
                end
            end
            dwrv_pkg::ACT_POP_FRONT:
            begin
                if (deque_occupancy == 0)
                    r.status = dwrv_pkg::ST_EMPTY;
                else
                begin
                    r.value_out = deque_entries[0];
                    for (i = 0; i < deque_occupancy - 1; i++)
                        deque_entries[i] = deque_entries[i+1];
                    deque_occupancy--;
                end
            end
            dwrv_pkg::ACT_POP_BACK:
            begin
                if (deque_occupancy == 0)
                    r.status = dwrv_pkg::ST_EMPTY;
                else
                begin
                    r.value_out = deque_entries[deque_occupancy-1];
                    deque_occupancy--;
                end
            end
            dwrv_pkg::ACT_REMOVE:
            begin
                if (pos >= deque_occupancy)
                    r.status = dwrv_pkg::ST_NOTFOUND;
                else
                begin
                    for (i = pos; i < deque_occupancy - 1; i++)
                        deque_entries[i] = deque_entries[i+1];
                    deque_occupancy--;
                end
            end
            dwrv_pkg::ACT_FIND:
            begin
                if (pos >= deque_occupancy)
                    r.status = dwrv_pkg::ST_NOTFOUND;
            end
            default: ;
        endcase
        r.count = dwrv_pkg::COUNT_W'(deque_occupancy);
        return r;
    endfunction

    // mostly values likely to match: small pool with duplicates, held entries, extremes
    function automatic logic signed [dwrv_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return dwrv_pkg::DATA_W'($urandom_range(0, 6)) - 3;
        else if (sel < 7 && deque_occupancy > 0)
            return deque_entries[$urandom_range(0, deque_occupancy - 1)];
        else if (sel == 7)
            return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        else
            return $urandom();
    endfunction

    function automatic logic [dwrv_pkg::ACT_W-1:0] pick_action(input mix_t mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                push_pct = 60;
                pop_pct = 15;
            end
            MIX_DRAIN:
            begin
                push_pct = 15;
                pop_pct = 60;
            end
            default:
            begin
                push_pct = 35;
                pop_pct = 35;
            end
        endcase
        if (roll < push_pct)
            return $urandom_range(0, 1) ? dwrv_pkg::ACT_PUSH_BACK : dwrv_pkg::ACT_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? dwrv_pkg::ACT_POP_BACK : dwrv_pkg::ACT_POP_FRONT;
        else if (roll < 95)
            return $urandom_range(0, 1) ? dwrv_pkg::ACT_FIND : dwrv_pkg::ACT_REMOVE;
        else
            return $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [dwrv_pkg::ACT_W-1:0] act,
                             input logic signed [dwrv_pkg::DATA_W-1:0] val);
        dwrv_pkg::req_item_t it;
        int                  gap;
        it.action = act;
        it.value = val;
        if (sender_gaps && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        req_item <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        expected_results.push_back(deque_apply(it));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_store();
        send_item(dwrv_pkg::ACT_POP_FRONT, 32'sd7);
        send_item(dwrv_pkg::ACT_POP_BACK, VAL_MAX);
        send_item(dwrv_pkg::ACT_REMOVE, 32'sd0);
        send_item(dwrv_pkg::ACT_FIND, VAL_MIN);
        send_item(ACT_SPARE_6, -32'sd1);
        send_item(ACT_SPARE_7, 32'sd5);
    endtask

    task automatic test_push_and_find();
        send_item(dwrv_pkg::ACT_PUSH_FRONT, VAL_MIN);
        send_item(dwrv_pkg::ACT_PUSH_BACK, VAL_MAX);
        send_item(dwrv_pkg::ACT_PUSH_BACK, 32'sd0);
        send_item(dwrv_pkg::ACT_PUSH_FRONT, -32'sd1);
        send_item(dwrv_pkg::ACT_FIND, VAL_MAX);
        send_item(dwrv_pkg::ACT_FIND, 32'sd5);
        send_item(ACT_SPARE_6, VAL_MIN);
    endtask

    task automatic test_remove_and_pop();
        send_item(dwrv_pkg::ACT_REMOVE, 32'sd5);
        send_item(dwrv_pkg::ACT_PUSH_BACK, -32'sd1);
        send_item(dwrv_pkg::ACT_REMOVE, -32'sd1);
        send_item(dwrv_pkg::ACT_POP_FRONT, 32'sd0);
        send_item(dwrv_pkg::ACT_POP_BACK, 32'sd0);
        send_item(dwrv_pkg::ACT_REMOVE, VAL_MAX);
        send_item(dwrv_pkg::ACT_POP_BACK, 32'sd0);
        wait_for_results();
    endtask

    task automatic test_output_hold();
        int n;
        sender_gaps = 1'b0;
        hold_request = 1'b1;
        for (n = 0; n < 40; n++)
            send_item(pick_action(MIX_EVEN), pick_value());
        sender_gaps = 1'b1;
        wait_for_results();
    endtask

    task automatic test_random_mix(input int n_items);
        int   n;
        mix_t mix;
        mix = MIX_FILL;
        for (n = 0; n < n_items; n++)
        begin
            if (n % 40 == 0)
                mix = mix_t'($urandom_range(0, 2));
            if (n % 250 == 249)
                wait_for_results();
            send_item(pick_action(mix), pick_value());
        end
        wait_for_results();
    endtask

    // receiver: long hold on request, otherwise segments of varying stall density
    initial
    begin
        int hold_left;
        int seg_left;
        int stall_mode;
        hold_left = 0;
        seg_left = 0;
        stall_mode = 0;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 60);
                    stall_mode = $urandom_range(0, 3);
                end
                seg_left--;
                case (stall_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 1) == 1);
                    default: rsp_stall <= (seg_left % 4 < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        dwrv_pkg::rsp_item_t exp_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("response with no transaction outstanding");
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (rsp_item.status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, rsp_item.status);
                    mismatches++;
                end
                if (rsp_item.value_out !== exp_r.value_out)
                begin
                    $error("value_out: expected %0d, actual %0d",
                           exp_r.value_out, rsp_item.value_out);
                    mismatches++;
                end
                if (rsp_item.count !== exp_r.count)
                begin
                    $error("count: expected %0d, actual %0d", exp_r.count, rsp_item.count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_item = '0;
        mismatches = 0;
        cycle_count = 0;
        burst_left = 0;
        sender_gaps = 1'b1;
        hold_request = 1'b0;
        deque_occupancy = 0;
        foreach (deque_entries[i])
            deque_entries[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_store();
        test_push_and_find();
        test_remove_and_pop();
        test_output_hold();
        test_random_mix(1000);

        wait_for_results();
        repeat (5) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/dwrv_pkg.sv
src/dwrv_cell.sv
src/deque_with_remove_by_value_unit.sv
tb/testbench.sv
